// File: sv/tsn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tsn_pkg;

    // telnet command bytes
    localparam logic [7:0] T_SE   = 8'd240;
    localparam logic [7:0] T_SB   = 8'd250;
    localparam logic [7:0] T_WILL = 8'd251;
    localparam logic [7:0] T_WONT = 8'd252;
    localparam logic [7:0] T_DO   = 8'd253;
    localparam logic [7:0] T_DONT = 8'd254;
    localparam logic [7:0] T_IAC  = 8'd255;

    // option numbers
    localparam logic [7:0] OPT_BINARY = 8'd0;
    localparam logic [7:0] OPT_ECHO   = 8'd1;
    localparam logic [7:0] OPT_SGA    = 8'd3;
    localparam logic [7:0] OPT_TTYPE  = 8'd24;
    localparam logic [7:0] OPT_NAWS   = 8'd31;
    localparam logic [7:0] TTYPE_SEND = 8'd1;
    localparam logic [7:0] TTYPE_IS   = 8'd0;

    // request types
    localparam logic [1:0] REQ_NET    = 2'd0;
    localparam logic [1:0] REQ_USER   = 2'd1;
    localparam logic [1:0] REQ_RESIZE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_NAME_LOW  = 2'd0;
    localparam logic [1:0] CFG_NAME_HIGH = 2'd1;
    localparam logic [1:0] CFG_NAME_LEN  = 2'd2;

    // parser states
    localparam logic [2:0] PS_DATA   = 3'd0;
    localparam logic [2:0] PS_CMD    = 3'd1;
    localparam logic [2:0] PS_OPT    = 3'd2;
    localparam logic [2:0] PS_SUB    = 3'd3;
    localparam logic [2:0] PS_SUBIAC = 3'd4;

    // pending verb codes (verb minus WILL)
    localparam logic [1:0] PV_WILL = 2'd0;
    localparam logic [1:0] PV_WONT = 2'd1;
    localparam logic [1:0] PV_DO   = 2'd2;
    localparam logic [1:0] PV_DONT = 2'd3;

    // job kinds handed from front to back
    localparam logic [1:0] K_BYTE  = 2'd0;
    localparam logic [1:0] K_CMD   = 2'd1;
    localparam logic [1:0] K_WIN   = 2'd2;
    localparam logic [1:0] K_TTYPE = 2'd3;

    localparam logic [15:0] RESET_COLS = 16'd80;
    localparam logic [15:0] RESET_ROWS = 16'd24;
    localparam logic [4:0]  BUILTIN_LEN = 5'd14;
    localparam logic [4:0]  HEADER_LEN  = 5'd4;

    typedef logic [1:0] job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic        dest;
        logic        esc;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic        win;
        logic [15:0] cols;
        logic [15:0] rows;
    } job_t;

    // built-in terminal name xterm-256color
    function automatic logic [7:0] builtin_byte(input logic [3:0] idx);
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = 8'h78;
            4'd1:    b = 8'h74;
            4'd2:    b = 8'h65;
            4'd3:    b = 8'h72;
            4'd4:    b = 8'h6d;
            4'd5:    b = 8'h2d;
            4'd6:    b = 8'h32;
            4'd7:    b = 8'h35;
            4'd8:    b = 8'h36;
            4'd9:    b = 8'h63;
            4'd10:   b = 8'h6f;
            4'd11:   b = 8'h6c;
            4'd12:   b = 8'h6f;
            4'd13:   b = 8'h72;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: sv/tsn_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

// request channel
interface tsn_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  data_byte;
    logic [15:0] new_cols;
    logic [15:0] new_rows;

    modport source (output valid, req_type, data_byte, new_cols, new_rows, input ready);
    modport sink (input valid, req_type, data_byte, new_cols, new_rows, output ready);
endinterface

// result channel
interface tsn_res_if;
    logic       valid;
    logic       ready;
    logic       dest;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, dest, out_byte, last_of_run, input ready);
    modport sink (input valid, dest, out_byte, last_of_run, output ready);
endinterface

`default_nettype wire

// File: sv/tsn_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tsn_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    tsn_req_if.sink            req,
    input  wire logic          q_full,
    output logic               push,
    output tsn_pkg::job_t      push_job
);

    logic [2:0]  parse_state_reg, parse_state_next;
    logic [1:0]  pending_verb_reg, pending_verb_next;
    logic [1:0]  sub_count_reg, sub_count_next;
    logic [7:0]  sub_first_reg, sub_first_next;
    logic [7:0]  sub_second_reg, sub_second_next;
    logic        naws_on_reg, naws_on_next;
    logic [15:0] window_cols_reg, window_cols_next;
    logic [15:0] window_rows_reg, window_rows_next;

    logic        accept;
    logic        do_store;
    logic [7:0]  ch;

    assign req.ready = !q_full;
    assign accept    = req.valid && !q_full;
    assign ch        = req.data_byte;

    // parser, option policy and job build
    always_comb
    begin
        parse_state_next  = parse_state_reg;
        pending_verb_next = pending_verb_reg;
        sub_count_next    = sub_count_reg;
        sub_first_next    = sub_first_reg;
        sub_second_next   = sub_second_reg;
        naws_on_next      = naws_on_reg;
        window_cols_next  = window_cols_reg;
        window_rows_next  = window_rows_reg;
        do_store          = 1'b0;
        push              = 1'b0;
        push_job          = '0;
        push_job.cols     = window_cols_reg;
        push_job.rows     = window_rows_reg;

        if (accept)
        begin
            case (req.req_type)
                tsn_pkg::REQ_NET:
                begin
                    unique case (parse_state_reg)
                        tsn_pkg::PS_CMD:
                        begin
                            parse_state_next = tsn_pkg::PS_DATA;
                            if (ch == tsn_pkg::T_IAC)
                            begin
                                push        = 1'b1;
                                push_job.kind = tsn_pkg::K_BYTE;
                                push_job.b0 = ch;
                            end
                            else if (ch >= tsn_pkg::T_WILL && ch <= tsn_pkg::T_DONT)
                            begin
                                pending_verb_next = 2'(ch - tsn_pkg::T_WILL);
                                parse_state_next  = tsn_pkg::PS_OPT;
                            end
                            else if (ch == tsn_pkg::T_SB)
                            begin
                                sub_count_next   = 2'd0;
                                parse_state_next = tsn_pkg::PS_SUB;
                            end
                        end
                        tsn_pkg::PS_OPT:
                        begin
                            parse_state_next = tsn_pkg::PS_DATA;
                            push             = 1'b1;
                            push_job.kind    = tsn_pkg::K_CMD;
                            push_job.dest    = 1'b1;
                            push_job.b1      = ch;
                            unique case (pending_verb_reg)
                                tsn_pkg::PV_DO:
                                begin
                                    if (ch == tsn_pkg::OPT_BINARY || ch == tsn_pkg::OPT_SGA ||
                                        ch == tsn_pkg::OPT_TTYPE || ch == tsn_pkg::OPT_NAWS)
                                    begin
                                        push_job.b0 = tsn_pkg::T_WILL;
                                        if (ch == tsn_pkg::OPT_NAWS)
                                        begin
                                            naws_on_next = 1'b1;
                                            push_job.win = 1'b1;
                                        end
                                    end
                                    else
                                    begin
                                        push_job.b0 = tsn_pkg::T_WONT;
                                    end
                                end
                                tsn_pkg::PV_DONT:
                                begin
                                    if (ch == tsn_pkg::OPT_NAWS)
                                        naws_on_next = 1'b0;
                                    push_job.b0 = tsn_pkg::T_WONT;
                                end
                                tsn_pkg::PV_WILL:
                                begin
                                    if (ch == tsn_pkg::OPT_BINARY || ch == tsn_pkg::OPT_ECHO ||
                                        ch == tsn_pkg::OPT_SGA)
                                        push_job.b0 = tsn_pkg::T_DO;
                                    else
                                        push_job.b0 = tsn_pkg::T_DONT;
                                end
                                default:
                                begin
                                    push_job.b0 = tsn_pkg::T_DONT;
                                end
                            endcase
                        end
                        tsn_pkg::PS_SUB:
                        begin
                            if (ch == tsn_pkg::T_IAC)
                                parse_state_next = tsn_pkg::PS_SUBIAC;
                            else
                                do_store = 1'b1;
                        end
                        tsn_pkg::PS_SUBIAC:
                        begin
                            if (ch == tsn_pkg::T_SE)
                            begin
                                if (sub_count_reg == 2'd2 && sub_first_reg == tsn_pkg::OPT_TTYPE &&
                                    sub_second_reg == tsn_pkg::TTYPE_SEND)
                                begin
                                    push          = 1'b1;
                                    push_job.kind = tsn_pkg::K_TTYPE;
                                    push_job.dest = 1'b1;
                                end
                                sub_count_next   = 2'd0;
                                parse_state_next = tsn_pkg::PS_DATA;
                            end
                            else
                            begin
                                do_store         = (ch == tsn_pkg::T_IAC);
                                parse_state_next = tsn_pkg::PS_SUB;
                            end
                        end
                        default:
                        begin
                            // data state, unused codes behave the same
                            if (ch == tsn_pkg::T_IAC)
                            begin
                                parse_state_next = tsn_pkg::PS_CMD;
                            end
                            else
                            begin
                                parse_state_next = tsn_pkg::PS_DATA;
                                push             = 1'b1;
                                push_job.kind    = tsn_pkg::K_BYTE;
                                push_job.b0      = ch;
                            end
                        end
                    endcase
                end
                tsn_pkg::REQ_USER:
                begin
                    push          = 1'b1;
                    push_job.kind = tsn_pkg::K_BYTE;
                    push_job.dest = 1'b1;
                    push_job.esc  = 1'b1;
                    push_job.b0   = ch;
                end
                tsn_pkg::REQ_RESIZE:
                begin
                    if (req.new_cols != 16'd0 && req.new_rows != 16'd0)
                    begin
                        window_cols_next = req.new_cols;
                        window_rows_next = req.new_rows;
                        push_job.kind    = tsn_pkg::K_WIN;
                        push_job.dest    = 1'b1;
                        push_job.cols    = req.new_cols;
                        push_job.rows    = req.new_rows;
                        push             = naws_on_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // keep the first two subnegotiation bytes
        if (do_store)
        begin
            if (sub_count_reg == 2'd0)
                sub_first_next = ch;
            else if (sub_count_reg == 2'd1)
                sub_second_next = ch;
            if (sub_count_reg < 2'd2)
                sub_count_next = sub_count_reg + 2'd1;
        end
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_state_reg  <= tsn_pkg::PS_DATA;
            pending_verb_reg <= 2'd0;
            sub_count_reg    <= 2'd0;
            sub_first_reg    <= 8'd0;
            sub_second_reg   <= 8'd0;
            naws_on_reg      <= 1'b0;
            window_cols_reg  <= tsn_pkg::RESET_COLS;
            window_rows_reg  <= tsn_pkg::RESET_ROWS;
        end
        else
        begin
            parse_state_reg  <= parse_state_next;
            pending_verb_reg <= pending_verb_next;
            sub_count_reg    <= sub_count_next;
            sub_first_reg    <= sub_first_next;
            sub_second_reg   <= sub_second_next;
            naws_on_reg      <= naws_on_next;
            window_cols_reg  <= window_cols_next;
            window_rows_reg  <= window_rows_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/tsn_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module tsn_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire tsn_pkg::job_t push_job,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output tsn_pkg::job_t      head_job
);

    // two-entry job queue
    tsn_pkg::job_t mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_job   = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

`default_nettype wire

// File: sv/tsn_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tsn_back #(
    parameter int MAX_TERM_LEN = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          head_valid,
    input  wire tsn_pkg::job_t head_job,
    output logic               pop,
    input  wire logic [63:0]   name_low,
    input  wire logic [63:0]   name_high,
    input  wire logic [4:0]    name_len,
    tsn_res_if.source          res
);

    localparam logic [4:0] MAX_LEN = 5'(MAX_TERM_LEN);

    logic [4:0] step_reg, step_next;
    logic       dup_reg, dup_next;
    logic       win_reg, win_next;
    logic       out_valid_reg;
    logic       dest_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    logic       go;
    logic       emit;
    logic       last;
    logic       cur_dest;
    logic [7:0] cur_byte;
    logic [7:0] win_byte;
    logic       win_esc;
    logic [4:0] eff_len;
    logic       use_builtin;
    logic [4:0] name_end;
    logic [4:0] name_pos;
    logic [3:0] name_idx;
    logic [7:0] cfg_byte;
    logic [7:0] name_byte;

    assign go = head_valid && (!out_valid_reg || res.ready);

    // window report byte for the current step
    always_comb
    begin
        win_esc = 1'b0;
        case (step_reg)
            5'd0: win_byte = tsn_pkg::T_IAC;
            5'd1: win_byte = tsn_pkg::T_SB;
            5'd2: win_byte = tsn_pkg::OPT_NAWS;
            5'd3:
            begin
                win_byte = head_job.cols[15:8];
                win_esc  = 1'b1;
            end
            5'd4:
            begin
                win_byte = head_job.cols[7:0];
                win_esc  = 1'b1;
            end
            5'd5:
            begin
                win_byte = head_job.rows[15:8];
                win_esc  = 1'b1;
            end
            5'd6:
            begin
                win_byte = head_job.rows[7:0];
                win_esc  = 1'b1;
            end
            5'd7:    win_byte = tsn_pkg::T_IAC;
            default: win_byte = tsn_pkg::T_SE;
        endcase
    end

    // terminal name byte selection
    assign eff_len     = (name_len > MAX_LEN) ? MAX_LEN : name_len;
    assign use_builtin = (name_len == 5'd0);
    assign name_end    = (use_builtin ? tsn_pkg::BUILTIN_LEN : eff_len) + tsn_pkg::HEADER_LEN;
    assign name_pos    = step_reg - tsn_pkg::HEADER_LEN;
    assign name_idx    = name_pos[3:0];
    assign cfg_byte    = name_idx[3] ? name_high[{name_idx[2:0], 3'b000} +: 8]
                                     : name_low[{name_idx[2:0], 3'b000} +: 8];
    assign name_byte   = use_builtin ? tsn_pkg::builtin_byte(name_idx) : cfg_byte;

    // output sequencer
    always_comb
    begin
        step_next = step_reg + 5'd1;
        dup_next  = 1'b0;
        win_next  = win_reg;
        emit      = 1'b1;
        last      = 1'b0;
        cur_dest  = 1'b1;
        cur_byte  = 8'd0;

        if (win_reg || head_job.kind == tsn_pkg::K_WIN)
        begin
            cur_byte = win_byte;
            if (win_esc && win_byte == tsn_pkg::T_IAC && !dup_reg)
            begin
                dup_next  = 1'b1;
                step_next = step_reg;
            end
            else if (step_reg == 5'd8)
            begin
                last = 1'b1;
            end
        end
        else
        begin
            case (head_job.kind)
                tsn_pkg::K_BYTE:
                begin
                    cur_dest = head_job.dest;
                    cur_byte = head_job.b0;
                    if (head_job.esc && head_job.b0 == tsn_pkg::T_IAC && !dup_reg)
                        dup_next = 1'b1;
                    else
                        last = 1'b1;
                end
                tsn_pkg::K_CMD:
                begin
                    case (step_reg)
                        5'd0:    cur_byte = tsn_pkg::T_IAC;
                        5'd1:    cur_byte = head_job.b0;
                        default: cur_byte = head_job.b1;
                    endcase
                    if (step_reg == 5'd2)
                    begin
                        if (head_job.win)
                        begin
                            win_next  = 1'b1;
                            step_next = 5'd0;
                        end
                        else
                        begin
                            last = 1'b1;
                        end
                    end
                end
                default:
                begin
                    // terminal-type reply: header, name, trailer
                    if (step_reg < tsn_pkg::HEADER_LEN)
                    begin
                        case (step_reg)
                            5'd0:    cur_byte = tsn_pkg::T_IAC;
                            5'd1:    cur_byte = tsn_pkg::T_SB;
                            5'd2:    cur_byte = tsn_pkg::OPT_TTYPE;
                            default: cur_byte = tsn_pkg::TTYPE_IS;
                        endcase
                    end
                    else if (step_reg < name_end)
                    begin
                        cur_byte = name_byte;
                        emit     = (name_byte != tsn_pkg::T_IAC);
                    end
                    else if (step_reg == name_end)
                    begin
                        cur_byte = tsn_pkg::T_IAC;
                    end
                    else
                    begin
                        cur_byte = tsn_pkg::T_SE;
                        last     = 1'b1;
                    end
                end
            endcase
        end

        if (last)
        begin
            step_next = 5'd0;
            win_next  = 1'b0;
        end
    end

    assign pop = go && last;

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 5'd0;
            dup_reg  <= 1'b0;
            win_reg  <= 1'b0;
        end
        else if (go)
        begin
            step_reg <= step_next;
            dup_reg  <= dup_next;
            win_reg  <= win_next;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || res.ready)
            out_valid_reg <= go && emit;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (go && emit)
        begin
            dest_reg <= cur_dest;
            byte_reg <= cur_byte;
            last_reg <= last;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.dest        = dest_reg;
    assign res.out_byte    = byte_reg;
    assign res.last_of_run = last_reg;

endmodule

`default_nettype wire

// File: sv/telnet_stream_negotiator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// A result passes through the job queue and the output register after its request is accepted.
// Throughput: one result byte per back-end cycle while res.ready does not stall the output
//   (a data byte, a window report with IAC bytes doubled, or a DO NAWS answer and window
//   report); a terminal-type reply also spends a step on each dropped name byte; a two-job
//   queue lets requests with no result pass at one a cycle while the queue is not full.
// Reset: parser in data state, NAWS off, window 80x24, name registers zero, queue and output empty.

module telnet_stream_negotiator_unit #(
    parameter int MAX_TERM_LEN = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    tsn_req_if.sink          req,
    tsn_res_if.source        res,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    logic [63:0] name_low_reg;
    logic [63:0] name_high_reg;
    logic [4:0]  name_len_reg;

    logic          q_full;
    logic          push;
    tsn_pkg::job_t push_job;
    logic          pop;
    logic          head_valid;
    tsn_pkg::job_t head_job;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_low_reg  <= 64'd0;
            name_high_reg <= 64'd0;
            name_len_reg  <= 5'd0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                tsn_pkg::CFG_NAME_LOW:  name_low_reg  <= cfg_data;
                tsn_pkg::CFG_NAME_HIGH: name_high_reg <= cfg_data;
                tsn_pkg::CFG_NAME_LEN:  name_len_reg  <= cfg_data[4:0];
                default:
                begin
                end
            endcase
        end
    end

    // request parser and classifier
    tsn_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    // job queue
    tsn_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // result sequencer
    tsn_back #(
        .MAX_TERM_LEN (MAX_TERM_LEN)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .name_low   (name_low_reg),
        .name_high  (name_high_reg),
        .name_len   (name_len_reg),
        .res        (res)
    );

endmodule

`default_nettype wire
